@@ rtl/priority_wait_queue_fifo_ties_assert.svh @@
// Assertion macros shared by the checker of the priority wait queue.
// No dependencies; expects signals clk and rst_n in the including scope.
`ifndef PRIORITY_WAIT_QUEUE_FIFO_TIES_ASSERT_SVH
`define PRIORITY_WAIT_QUEUE_FIFO_TIES_ASSERT_SVH

// Check a property outside reset.
`define PWQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property at every edge, reset included.
`define PWQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/pwq_pkg.sv @@
// Package for the priority wait queue: defaults, command and status codes,
// sequencer phases and the control struct driven into the cell chain.
package pwq_pkg;

  localparam int DEPTH_DEF     = 32;
  localparam int PRIO_BITS_DEF = 8;
  localparam int ID_BITS_DEF   = 8;

  localparam int CMD_W    = 2;
  localparam int FIELD_W  = 8;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 6;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD    = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_CHOOSE = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 3'd0,
    STAT_NOT_FOUND = 3'd1,
    STAT_FULL      = 3'd2,
    STAT_EMPTY     = 3'd3,
    STAT_DUP       = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_EVAL,
    PH_APPLY
  } phase_t;

  typedef struct packed {
    logic eval;
    logic insert;
    logic shift;
  } ctrl_t;

endpackage

@@ rtl/pwq_cell.sv @@
// One slot of the sorted chain: holds a waiter, registers its compare flags
// and takes data from the new entry or its left or right neighbour. Depends on pwq_pkg.
module pwq_cell #(
  parameter int DEPTH     = pwq_pkg::DEPTH_DEF,
  parameter int PRIO_BITS = pwq_pkg::PRIO_BITS_DEF,
  parameter int ID_BITS   = pwq_pkg::ID_BITS_DEF,
  parameter int IDX       = 0
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  pwq_pkg::ctrl_t             ctrl,
  input  logic [$clog2(DEPTH)-1:0]   gap_pos,
  input  logic [ID_BITS-1:0]         new_id,
  input  logic [PRIO_BITS-1:0]       new_prio,
  input  logic                       left_ge,
  input  logic                       left_valid,
  input  logic [ID_BITS-1:0]         left_id,
  input  logic [PRIO_BITS-1:0]       left_prio,
  input  logic                       right_valid,
  input  logic [ID_BITS-1:0]         right_id,
  input  logic [PRIO_BITS-1:0]       right_prio,
  output logic                       valid,
  output logic [ID_BITS-1:0]         id,
  output logic [PRIO_BITS-1:0]       prio,
  output logic                       ge,
  output logic                       match
);

  localparam int GAP_W = $clog2(DEPTH);

  logic                 valid_r, valid_nxt;
  logic [ID_BITS-1:0]   id_r, id_nxt;
  logic [PRIO_BITS-1:0] prio_r, prio_nxt;
  logic                 ge_r, ge_nxt;
  logic                 match_r, match_nxt;

  always_comb begin
    valid_nxt = valid_r;
    id_nxt    = id_r;
    prio_nxt  = prio_r;
    ge_nxt    = ge_r;
    match_nxt = match_r;
    if (ctrl.eval) begin
      ge_nxt    = valid_r && (prio_r >= new_prio);
      match_nxt = valid_r && (id_r == new_id);
    end
    if (ctrl.insert && !ge_r) begin
      if (left_ge) begin
        valid_nxt = 1'b1;
        id_nxt    = new_id;
        prio_nxt  = new_prio;
      end else begin
        valid_nxt = left_valid;
        id_nxt    = left_id;
        prio_nxt  = left_prio;
      end
    end
    if (ctrl.shift && (gap_pos <= GAP_W'(IDX))) begin
      valid_nxt = right_valid;
      id_nxt    = right_id;
      prio_nxt  = right_prio;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      ge_r    <= 1'b0;
      match_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      ge_r    <= ge_nxt;
      match_r <= match_nxt;
    end
  end

  always_ff @(posedge clk) begin
    id_r   <= id_nxt;
    prio_r <= prio_nxt;
  end

  assign valid = valid_r;
  assign id    = id_r;
  assign prio  = prio_r;
  assign ge    = ge_r;
  assign match = match_r;

endmodule

@@ rtl/priority_wait_queue_fifo_ties.sv @@
// A transfer is taken only in the idle phase; the eval phase registers the
// compare flags in every cell; the apply phase updates the chain, registers
// the result and returns to idle, held while a stalled result awaits out_ready.
// Reset (rst_n low, synchronous) empties the queue and drops any pending result.
// Depends on pwq_pkg and pwq_cell.
module priority_wait_queue_fifo_ties #(
  parameter int DEPTH     = pwq_pkg::DEPTH_DEF,
  parameter int PRIO_BITS = pwq_pkg::PRIO_BITS_DEF,
  parameter int ID_BITS   = pwq_pkg::ID_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [pwq_pkg::CMD_W-1:0]      in_cmd,
  input  logic [pwq_pkg::FIELD_W-1:0]    in_waiter_id,
  input  logic [pwq_pkg::FIELD_W-1:0]    in_priority_req,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [pwq_pkg::STATUS_W-1:0]   out_status,
  output logic                           out_chosen_valid,
  output logic [pwq_pkg::FIELD_W-1:0]    out_chosen_id,
  output logic [pwq_pkg::FIELD_W-1:0]    out_chosen_priority,
  output logic                           out_top_valid,
  output logic [pwq_pkg::FIELD_W-1:0]    out_top_priority,
  output logic [pwq_pkg::COUNT_W-1:0]    out_entry_count
);

  localparam int GAP_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int FW    = pwq_pkg::FIELD_W;

  pwq_pkg::phase_t phase_r, phase_nxt;
  pwq_pkg::ctrl_t  ctrl;
  logic            in_fire, out_free, apply_fire;

  pwq_pkg::cmd_t        cmd_r;
  logic [ID_BITS-1:0]   id_r;
  logic [PRIO_BITS-1:0] prio_r;
  logic [CNT_W-1:0]     count_r, count_nxt;

  logic                 cell_valid [DEPTH];
  logic [ID_BITS-1:0]   cell_id    [DEPTH];
  logic [PRIO_BITS-1:0] cell_prio  [DEPTH];
  logic                 cell_ge    [DEPTH];
  logic                 cell_match [DEPTH];

  logic                 lf_ge      [DEPTH];
  logic                 lf_valid   [DEPTH];
  logic [ID_BITS-1:0]   lf_id      [DEPTH];
  logic [PRIO_BITS-1:0] lf_prio    [DEPTH];
  logic                 rt_valid   [DEPTH];
  logic [ID_BITS-1:0]   rt_id      [DEPTH];
  logic [PRIO_BITS-1:0] rt_prio    [DEPTH];

  logic                 any_match;
  logic [GAP_W-1:0]     match_idx;
  logic [GAP_W-1:0]     gap_pos;
  logic                 do_insert, do_shift;
  pwq_pkg::status_t     status;
  logic                 chosen_valid;
  logic                 top0_valid;
  logic [PRIO_BITS-1:0] top0_prio;

  logic                 out_valid_r;
  logic [pwq_pkg::STATUS_W-1:0] status_r;
  logic                 chosen_valid_r;
  logic [FW-1:0]        chosen_id_r, chosen_prio_r;
  logic                 top_valid_r;
  logic [FW-1:0]        top_prio_r;
  logic [pwq_pkg::COUNT_W-1:0] entry_count_r;

  assign in_fire    = in_valid && in_ready;
  assign out_free   = !out_valid_r || out_ready;

  always_comb begin
    phase_nxt = phase_r;
    unique case (phase_r)
      pwq_pkg::PH_IDLE:  if (in_fire) phase_nxt = pwq_pkg::PH_EVAL;
      pwq_pkg::PH_EVAL:  phase_nxt = pwq_pkg::PH_APPLY;
      pwq_pkg::PH_APPLY: if (out_free) phase_nxt = pwq_pkg::PH_IDLE;
      default:           phase_nxt = pwq_pkg::PH_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    ctrl       = '0;
    apply_fire = 1'b0;
    unique case (phase_r)
      pwq_pkg::PH_IDLE:  in_ready = 1'b1;
      pwq_pkg::PH_EVAL:  ctrl.eval = 1'b1;
      pwq_pkg::PH_APPLY: apply_fire = out_free;
      default:           in_ready = 1'b0;
    endcase
    ctrl.insert = apply_fire && do_insert;
    ctrl.shift  = apply_fire && do_shift;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= pwq_pkg::PH_IDLE;
      count_r <= '0;
    end else begin
      phase_r <= phase_nxt;
      if (apply_fire) count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r  <= pwq_pkg::cmd_t'(in_cmd);
      id_r   <= ID_BITS'(in_waiter_id);
      prio_r <= PRIO_BITS'(in_priority_req);
    end
  end

  // neighbour wiring; cell 0 sees an always-staying entry on its left
  for (genvar i = 0; i < DEPTH; i++) begin : g_link
    if (i == 0) begin : g_first
      assign lf_ge[i]    = 1'b1;
      assign lf_valid[i] = 1'b0;
      assign lf_id[i]    = '0;
      assign lf_prio[i]  = '0;
    end else begin : g_mid
      assign lf_ge[i]    = cell_ge[i-1];
      assign lf_valid[i] = cell_valid[i-1];
      assign lf_id[i]    = cell_id[i-1];
      assign lf_prio[i]  = cell_prio[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign rt_valid[i] = 1'b0;
      assign rt_id[i]    = '0;
      assign rt_prio[i]  = '0;
    end else begin : g_inner
      assign rt_valid[i] = cell_valid[i+1];
      assign rt_id[i]    = cell_id[i+1];
      assign rt_prio[i]  = cell_prio[i+1];
    end

    pwq_cell #(
      .DEPTH     (DEPTH),
      .PRIO_BITS (PRIO_BITS),
      .ID_BITS   (ID_BITS),
      .IDX       (i)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctrl        (ctrl),
      .gap_pos     (gap_pos),
      .new_id      (id_r),
      .new_prio    (prio_r),
      .left_ge     (lf_ge[i]),
      .left_valid  (lf_valid[i]),
      .left_id     (lf_id[i]),
      .left_prio   (lf_prio[i]),
      .right_valid (rt_valid[i]),
      .right_id    (rt_id[i]),
      .right_prio  (rt_prio[i]),
      .valid       (cell_valid[i]),
      .id          (cell_id[i]),
      .prio        (cell_prio[i]),
      .ge          (cell_ge[i]),
      .match       (cell_match[i])
    );
  end

  always_comb begin
    any_match = 1'b0;
    match_idx = '0;
    for (int i = 0; i < DEPTH; i++) begin
      any_match = any_match | cell_match[i];
      if (cell_match[i]) match_idx = match_idx | GAP_W'(i);
    end
  end

  always_comb begin
    status       = pwq_pkg::STAT_OK;
    do_insert    = 1'b0;
    do_shift     = 1'b0;
    gap_pos      = '0;
    chosen_valid = 1'b0;
    count_nxt    = count_r;
    unique case (cmd_r)
      pwq_pkg::CMD_ADD: begin
        if (any_match) begin
          status = pwq_pkg::STAT_DUP;
        end else if (count_r == CNT_W'(DEPTH)) begin
          status = pwq_pkg::STAT_FULL;
        end else begin
          do_insert = 1'b1;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      pwq_pkg::CMD_REMOVE: begin
        if (!any_match) begin
          status = pwq_pkg::STAT_NOT_FOUND;
        end else begin
          do_shift  = 1'b1;
          gap_pos   = match_idx;
          count_nxt = count_r - CNT_W'(1);
        end
      end
      pwq_pkg::CMD_CHOOSE: begin
        if (count_r == '0) begin
          status = pwq_pkg::STAT_EMPTY;
        end else begin
          do_shift     = 1'b1;
          chosen_valid = 1'b1;
          count_nxt    = count_r - CNT_W'(1);
        end
      end
      pwq_pkg::CMD_NOP: status = pwq_pkg::STAT_OK;
      default:          status = pwq_pkg::STAT_OK;
    endcase
  end

  // head slot after this step
  always_comb begin
    top0_valid = cell_valid[0];
    top0_prio  = cell_prio[0];
    if (do_insert && !cell_ge[0]) begin
      top0_valid = 1'b1;
      top0_prio  = prio_r;
    end
    if (do_shift && gap_pos == '0) begin
      top0_valid = rt_valid[0];
      top0_prio  = rt_prio[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (apply_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (apply_fire) begin
      status_r       <= status;
      chosen_valid_r <= chosen_valid;
      chosen_id_r    <= chosen_valid ? FW'(cell_id[0]) : '0;
      chosen_prio_r  <= chosen_valid ? FW'(cell_prio[0]) : '0;
      top_valid_r    <= top0_valid;
      top_prio_r     <= top0_valid ? FW'(top0_prio) : '0;
      entry_count_r  <= pwq_pkg::COUNT_W'(count_nxt);
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status          = status_r;
  assign out_chosen_valid    = chosen_valid_r;
  assign out_chosen_id       = chosen_id_r;
  assign out_chosen_priority = chosen_prio_r;
  assign out_top_valid       = top_valid_r;
  assign out_top_priority    = top_prio_r;
  assign out_entry_count     = entry_count_r;

endmodule

@@ rtl/pwq_checker.sv @@
// Port-level checker for the priority wait queue, bound to the top level.
// Depends on pwq_pkg and priority_wait_queue_fifo_ties_assert.svh.
`include "priority_wait_queue_fifo_ties_assert.svh"

module pwq_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [pwq_pkg::STATUS_W-1:0]  out_status,
  input logic                          out_chosen_valid,
  input logic                          out_top_valid,
  input logic [pwq_pkg::FIELD_W-1:0]   out_top_priority,
  input logic [pwq_pkg::COUNT_W-1:0]   out_entry_count
);

  `PWQ_ASSERT_ALWAYS(a_reset_clears, !rst_n |=> !out_valid, "result valid after reset")

  `PWQ_ASSERT(a_busy_after_take, (in_valid && in_ready) |=> !in_ready, "second transfer taken while busy")

  `PWQ_ASSERT(a_stall_holds, (out_valid && !out_ready) |=> (out_valid && $stable(out_status)), "stalled result changed")

  `PWQ_ASSERT(a_chosen_ok, (out_valid && out_chosen_valid) |-> (out_status == pwq_pkg::STAT_OK), "pop with error status")

  `PWQ_ASSERT(a_empty_top, (out_valid && !out_top_valid) |-> (out_entry_count == '0 && out_top_priority == '0), "empty queue shows entries")

endmodule

bind priority_wait_queue_fifo_ties pwq_checker u_pwq_checker (.*);
